@@ rtl/core/cia402_csp_pkg.sv @@
package cia402_csp_pkg;

  // fixed field widths
  localparam int unsigned STATUS_W = 16;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned ANGLE_W  = 9;
  localparam int unsigned CTRL_W   = 16;
  localparam int unsigned MODE_W   = 8;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 72;

  // degrees in one shaft revolution
  localparam int unsigned DEG_PER_REV = 360;

  localparam int unsigned PULSES_PER_REV_DEF = 131072;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_DIRECTION = 1'b0,
    REG_STEP_SIZE = 1'b1
  } cfg_reg_e;

  localparam logic             DIRECTION_RST = 1'b1;
  localparam logic [STEP_W-1:0] STEP_SIZE_RST = 16'd100;

  // status word decode (low ten bits)
  localparam int unsigned      SW_FAULT_BIT   = 3;
  localparam logic [9:0]       SW_DISABLED    = 10'h250;
  localparam logic [9:0]       SW_READY       = 10'h270;
  localparam logic [9:0]       SW_SWITCHED_ON = 10'h231;
  localparam logic [9:0]       SW_OP_ENABLED  = 10'h233;

  // control words
  localparam logic [CTRL_W-1:0] CW_RESET      = 16'h0008;
  localparam logic [CTRL_W-1:0] CW_FAULT      = 16'h0080;
  localparam logic [CTRL_W-1:0] CW_SHUTDOWN   = 16'h0006;
  localparam logic [CTRL_W-1:0] CW_SWITCH_ON  = 16'h0007;
  localparam logic [CTRL_W-1:0] CW_ENABLE_OP  = 16'h000F;
  localparam logic [CTRL_W-1:0] CW_QUICK_STOP = 16'h0002;

  // modes of operation
  localparam logic [MODE_W-1:0] MODE_NONE = 8'h00;
  localparam logic [MODE_W-1:0] MODE_CSP  = 8'h08;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic signed [POS_W-1:0] actual;
    logic                    run;
    logic [ANGLE_W-1:0]      target;
  } item_t;

endpackage

@@ rtl/core/cia402_csp_position_stepper.sv @@
// cia402 cyclic synchronous position stepper
//
// input stream (s_axis): one transaction per cyclic tick carrying the drive's
// status word, its actual position, a run flag and a target shaft angle.
// output stream (m_axis): one transaction per input with the control word,
// the modes-of-operation byte, the commanded position and the shaft angle.
// config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 direction, 1 step size); write only while no tick is in flight, unchecked.
//
// after the input register the shaft angle takes three stages: quotient of the
// magnitude by the pulses per revolution through a reciprocal multiply, the
// remainder by multiply and subtract, then degrees through a second reciprocal
// multiply; the drive state update happens in the cycle that loads the output
// register.
// throughput: one transaction per cycle unless stalled. every stage advances
// on its own, so bubbles close up and input keeps flowing while a result waits.
// when m_axis_tready is low the output holds and the pipeline fills behind
// it; s_axis_tready drops only once all five registers hold a tick.
// reset: control word 0x8, mode 0, position 0, angle 0, no target reached,
// direction 1 (step down), step size 100; the pipeline empties.
module cia402_csp_position_stepper #(
  parameter int unsigned PULSES_PER_REV = cia402_csp_pkg::PULSES_PER_REV_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,

  // tdata: drive_status[15:0], actual_position[47:16], run_enable[48],
  //        target_angle[57:49], zero fill[63:58]
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [cia402_csp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,

  // tdata: drive_control[15:0], operation_mode[23:16], target_position[55:24],
  //        position_angle[64:56], zero fill[71:65]
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [cia402_csp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_idx_i,
  input  logic [cia402_csp_pkg::STEP_W-1:0]      cfg_data_i
);

  localparam int unsigned MAG_W = cia402_csp_pkg::POS_W;
  localparam int unsigned QW    = cia402_csp_pkg::ANGLE_W;
  localparam int unsigned RW    = (PULSES_PER_REV > 1) ? $clog2(PULSES_PER_REV) : 1;

  // quotient by reciprocal: magnitude is at most 2^31, so a shift of 31 + RW
  // with a rounded-up multiplier is exact, and the multiplier fits 33 bits
  localparam int unsigned QSH = MAG_W - 1 + RW;
  localparam int unsigned QMW = MAG_W + 1;
  localparam logic [63:0] QM_FULL =
    ((64'd1 << QSH) + 64'(PULSES_PER_REV) - 64'd1) / 64'(PULSES_PER_REV);
  localparam logic [QMW-1:0] QM = QMW'(QM_FULL);
  localparam int unsigned QPW = MAG_W + QMW;

  localparam logic [MAG_W-1:0] PPR_M = MAG_W'(PULSES_PER_REV);

  // degrees by reciprocal: remainder below 2^RW, a shift of 2*RW is exact;
  // 360 needs 9 bits, one more for the round-up
  localparam int unsigned ASH = 2 * RW;
  localparam int unsigned KW  = RW + 10;
  localparam logic [63:0] AK_FULL =
    ((64'(cia402_csp_pkg::DEG_PER_REV) << ASH) + 64'(PULSES_PER_REV) - 64'd1) /
    64'(PULSES_PER_REV);
  localparam logic [KW-1:0] AK = KW'(AK_FULL);
  localparam int unsigned APW = RW + KW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic                              direction_q;
  logic [cia402_csp_pkg::STEP_W-1:0] step_size_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= cia402_csp_pkg::DIRECTION_RST;
      step_size_q <= cia402_csp_pkg::STEP_SIZE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cia402_csp_pkg::REG_DIRECTION: direction_q <= cfg_data_i[0];
        cia402_csp_pkg::REG_STEP_SIZE: step_size_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline registers
  // ---------------------------------------------------------------------------
  logic                  in_vld_q;
  cia402_csp_pkg::item_t in_itm_q;

  logic                  qt_vld_q;
  cia402_csp_pkg::item_t qt_itm_q;
  logic [MAG_W-1:0]      qt_mag_q;
  logic [MAG_W-1:0]      qt_quo_q;

  logic                  rm_vld_q;
  cia402_csp_pkg::item_t rm_itm_q;
  logic [RW-1:0]         rm_rem_q;

  logic                  ag_vld_q;
  cia402_csp_pkg::item_t ag_itm_q;
  logic [QW-1:0]         ag_angle_q;

  logic out_vld_q;

  // per-stage advance, so empty stages absorb stalls
  logic in_rdy, qt_rdy, rm_rdy, ag_rdy, out_rdy;

  assign out_rdy = !out_vld_q || m_axis_tready;
  assign ag_rdy  = !ag_vld_q || out_rdy;
  assign rm_rdy  = !rm_vld_q || ag_rdy;
  assign qt_rdy  = !qt_vld_q || rm_rdy;
  assign in_rdy  = !in_vld_q || qt_rdy;

  assign s_axis_tready = in_rdy;

  // ---------------------------------------------------------------------------
  // datapath of the angle pipeline
  // ---------------------------------------------------------------------------
  logic [MAG_W-1:0] in_act_u;
  logic [MAG_W-1:0] in_mag;

  // magnitude of the actual position; the most negative value stays 2^31
  assign in_act_u = in_itm_q.actual;
  assign in_mag   = in_act_u[MAG_W-1] ? (~in_act_u + MAG_W'(1)) : in_act_u;

  // whole revolutions in the magnitude
  logic [QPW-1:0]   qt_prod;
  logic [MAG_W-1:0] qt_quo_d;

  assign qt_prod  = QPW'(in_mag) * QPW'(QM);
  assign qt_quo_d = MAG_W'(qt_prod >> QSH);

  // pulses left over within the revolution
  logic [MAG_W-1:0] rm_diff;
  logic [RW-1:0]    rm_rem_d;

  assign rm_diff  = qt_mag_q - qt_quo_q * PPR_M;
  assign rm_rem_d = rm_diff[RW-1:0];

  // floor(remainder * 360 / pulses per revolution)
  logic [APW-1:0] ag_prod;
  logic [QW-1:0]  ag_angle_d;

  assign ag_prod    = APW'(rm_rem_q) * APW'(AK);
  assign ag_angle_d = QW'(ag_prod >> ASH);

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      qt_vld_q <= 1'b0;
      rm_vld_q <= 1'b0;
      ag_vld_q <= 1'b0;
    end else begin
      if (in_rdy) in_vld_q <= s_axis_tvalid;
      if (qt_rdy) qt_vld_q <= in_vld_q;
      if (rm_rdy) rm_vld_q <= qt_vld_q;
      if (ag_rdy) ag_vld_q <= rm_vld_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid) begin
      in_itm_q.status <= s_axis_tdata[15:0];
      in_itm_q.actual <= s_axis_tdata[47:16];
      in_itm_q.run    <= s_axis_tdata[48];
      in_itm_q.target <= s_axis_tdata[57:49];
    end
    if (qt_rdy && in_vld_q) begin
      qt_itm_q <= in_itm_q;
      qt_mag_q <= in_mag;
      qt_quo_q <= qt_quo_d;
    end
    if (rm_rdy && qt_vld_q) begin
      rm_itm_q <= qt_itm_q;
      rm_rem_q <= rm_rem_d;
    end
    if (ag_rdy && rm_vld_q) begin
      ag_itm_q   <= rm_itm_q;
      ag_angle_q <= ag_angle_d;
    end
  end

  // ---------------------------------------------------------------------------
  // drive state update, loads together with the output register
  // ---------------------------------------------------------------------------
  logic [cia402_csp_pkg::CTRL_W-1:0] control_q, control_d;
  logic [cia402_csp_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [MAG_W-1:0]                  cmd_pos_q, cmd_pos_d;
  logic [QW-1:0]                     angle_q, angle_d;
  logic                              reached_set_q, reached_set_d;
  logic [QW-1:0]                     reached_q, reached_d;

  cia402_csp_pkg::item_t fin;
  logic [QW-1:0]         fin_angle;
  logic                  update;

  assign fin       = ag_itm_q;
  assign fin_angle = ag_angle_q;
  assign update    = ag_vld_q && out_rdy;

  always_comb begin
    control_d     = control_q;
    mode_d        = mode_q;
    cmd_pos_d     = cmd_pos_q;
    angle_d       = angle_q;
    reached_set_d = reached_set_q;
    reached_d     = reached_q;

    // status decode
    if (fin.status[cia402_csp_pkg::SW_FAULT_BIT]) begin
      control_d = cia402_csp_pkg::CW_FAULT;
    end else begin
      unique case (fin.status[9:0]) inside
        cia402_csp_pkg::SW_DISABLED,
        cia402_csp_pkg::SW_READY:       control_d = cia402_csp_pkg::CW_SHUTDOWN;
        cia402_csp_pkg::SW_SWITCHED_ON: control_d = cia402_csp_pkg::CW_SWITCH_ON;
        cia402_csp_pkg::SW_OP_ENABLED:  control_d = cia402_csp_pkg::CW_ENABLE_OP;
        default: ;
      endcase
    end

    if (!fin.run) begin
      // quick stop, hold where the drive is
      control_d = cia402_csp_pkg::CW_QUICK_STOP;
      angle_d   = fin_angle;
      cmd_pos_d = fin.actual;
    end else begin
      if (control_d == cia402_csp_pkg::CW_SWITCH_ON) begin
        mode_d    = cia402_csp_pkg::MODE_CSP;
        cmd_pos_d = fin.actual;
      end
      // a latched target stops motion until a different angle is asked for
      if (control_d == cia402_csp_pkg::CW_ENABLE_OP &&
          !(reached_set_q && reached_q == fin.target)) begin
        angle_d = fin_angle;
        if (fin_angle == fin.target) begin
          cmd_pos_d     = fin.actual;
          reached_set_d = 1'b1;
          reached_d     = fin.target;
        end else if (direction_q) begin
          cmd_pos_d = cmd_pos_q - MAG_W'(step_size_q);
        end else begin
          cmd_pos_d = cmd_pos_q + MAG_W'(step_size_q);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q     <= 1'b0;
      control_q     <= cia402_csp_pkg::CW_RESET;
      mode_q        <= cia402_csp_pkg::MODE_NONE;
      cmd_pos_q     <= '0;
      angle_q       <= '0;
      reached_set_q <= 1'b0;
      reached_q     <= '0;
    end else begin
      if (update) begin
        out_vld_q     <= 1'b1;
        control_q     <= control_d;
        mode_q        <= mode_d;
        cmd_pos_q     <= cmd_pos_d;
        angle_q       <= angle_d;
        reached_set_q <= reached_set_d;
        reached_q     <= reached_d;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, angle_q, cmd_pos_q, mode_q, control_q};

endmodule

@@ rtl/core/cia402_csp_chk.sv @@
module cia402_csp_chk (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   m_axis_tvalid,
  input logic                                   m_axis_tready,
  input logic [cia402_csp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // shaft angle stays below one revolution
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[64:56] < 9'(cia402_csp_pkg::DEG_PER_REV))
    else $error("position angle out of range");

  // mode byte is either untouched or csp
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[23:16] == cia402_csp_pkg::MODE_NONE ||
                       m_axis_tdata[23:16] == cia402_csp_pkg::MODE_CSP))
    else $error("unexpected operation mode");

  // control word is one of the decoded commands
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:0] == cia402_csp_pkg::CW_RESET ||
                       m_axis_tdata[15:0] == cia402_csp_pkg::CW_FAULT ||
                       m_axis_tdata[15:0] == cia402_csp_pkg::CW_SHUTDOWN ||
                       m_axis_tdata[15:0] == cia402_csp_pkg::CW_SWITCH_ON ||
                       m_axis_tdata[15:0] == cia402_csp_pkg::CW_ENABLE_OP ||
                       m_axis_tdata[15:0] == cia402_csp_pkg::CW_QUICK_STOP))
    else $error("unexpected control word");

endmodule

bind cia402_csp_position_stepper cia402_csp_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
